@@ rtl/sorted_alarm_queue_top_assert.svh @@
// ---------------------------------------------------------------------------
// sorted_alarm_queue_top_assert.svh
// Assertion macros for the sorted alarm queue.
// ---------------------------------------------------------------------------
`ifndef SORTED_ALARM_QUEUE_TOP_ASSERT_SVH
`define SORTED_ALARM_QUEUE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SAQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SAQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/saq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// saq_pkg
// Word types and action codes shared by the sorted alarm queue.
// ---------------------------------------------------------------------------
package saq_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] fire_time;
    logic [15:0] alarm_tag;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] removed_id;
    logic [31:0] removed_time;
    logic [31:0] head_time;
    logic        queue_empty;
    logic [4:0]  queue_length;
  } out_word_t;

  typedef struct packed {
    logic [31:0] fire_time;
    logic [15:0] alarm_tag;
  } entry_t;

  localparam int LEN_W = 5;

endpackage

@@ rtl/sorted_alarm_queue_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_alarm_queue_top
// Bounded alarm queue kept sorted by fire time, walked by a small sequencer.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_ready  | in_data  (in_word_t)
//  out     | output    | out_valid / out_ready| out_data (out_word_t)
//
// An operation scans the list, shifts entries to open or close a gap, then reads
// the head to build the result word; a query and an insert into a full queue go
// straight to the head. Scan and shift go entry by entry, since every step goes
// through the single registered read port of the entry memory.
// Reset clears the alarm count; memory contents are never read before written.
// in_ready is high only while the sequencer is idle; a waiting result holds
// in the output register while the next operation runs.
// ---------------------------------------------------------------------------
module sorted_alarm_queue_top
  import saq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SCAN_RD  = 9'b000000010,
    ST_SCAN_CHK = 9'b000000100,
    ST_MOVE_RD  = 9'b000001000,
    ST_MOVE_WR  = 9'b000010000,
    ST_PLACE    = 9'b000100000,
    ST_HEAD_RD  = 9'b001000000,
    ST_HEAD_CHK = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic [1:0]    act, act_next;
  logic [31:0]   req_time, req_time_next;
  logic [15:0]   req_id, req_id_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] mv, mv_next;
  logic          fail, fail_next;
  logic [31:0]   rem_time, rem_time_next;
  logic [15:0]   rem_id, rem_id_next;
  logic [31:0]   head, head_next;
  logic          out_valid_next;
  out_word_t     out_data_next;

  logic          scan_hit;
  logic [CW-1:0] mv_inc;
  logic [CW-1:0] mv_dec;
  logic [CW+LEN_W-1:0] len_ext;

  assign in_ready = (state == ST_IDLE);
  assign mv_inc   = mv + CW'(1);
  assign mv_dec   = mv - CW'(1);
  assign len_ext  = {{LEN_W{1'b0}}, count};

  always_comb begin
    case (act)
      ACT_INSERT:  scan_hit = !(rd_data.fire_time < req_time);
      ACT_DEQUEUE: scan_hit = 1'b1;
      ACT_DELETE:  scan_hit = (rd_data.alarm_tag == req_id);
      default:     scan_hit = 1'b0;
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next     = state;
    act_next       = act;
    req_time_next  = req_time;
    req_id_next    = req_id;
    count_next     = count;
    idx_next       = idx;
    mv_next        = mv;
    fail_next      = fail;
    rem_time_next  = rem_time;
    rem_id_next    = rem_id;
    head_next      = head;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act_next      = in_data.action;
          req_time_next = in_data.fire_time;
          req_id_next   = in_data.alarm_tag;
          fail_next     = 1'b0;
          rem_time_next = '0;
          rem_id_next   = '0;
          idx_next      = '0;
          if (in_data.action == ACT_INSERT && count == FULL_COUNT) begin
            fail_next  = 1'b1;
            state_next = ST_HEAD_RD;
          end else if (in_data.action == ACT_QUERY) begin
            state_next = ST_HEAD_RD;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (idx == count) begin
          // End of list: insert goes at the tail, remove finds nothing.
          if (act == ACT_INSERT) begin
            mv_next    = count;
            state_next = ST_MOVE_RD;
          end else begin
            fail_next  = 1'b1;
            state_next = ST_HEAD_RD;
          end
        end else begin
          rd_addr    = idx[AW-1:0];
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          if (act == ACT_INSERT) begin
            mv_next = count;
          end else begin
            rem_time_next = rd_data.fire_time;
            rem_id_next   = rd_data.alarm_tag;
            mv_next       = idx;
          end
          state_next = ST_MOVE_RD;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = ST_SCAN_RD;
        end
      end
      ST_MOVE_RD: begin
        if (act == ACT_INSERT) begin
          // Open a gap at idx by shifting toward the tail.
          if (mv == idx) begin
            state_next = ST_PLACE;
          end else begin
            rd_addr    = mv_dec[AW-1:0];
            state_next = ST_MOVE_WR;
          end
        end else begin
          // Close the gap by shifting toward the head.
          if (mv_inc >= count) begin
            count_next = count - CW'(1);
            state_next = ST_HEAD_RD;
          end else begin
            rd_addr    = mv_inc[AW-1:0];
            state_next = ST_MOVE_WR;
          end
        end
      end
      ST_MOVE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = mv[AW-1:0];
        mem_wdata  = rd_data;
        mv_next    = (act == ACT_INSERT) ? mv_dec : mv_inc;
        state_next = ST_MOVE_RD;
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = '{fire_time: req_time, alarm_tag: req_id};
        count_next = count + CW'(1);
        state_next = ST_HEAD_RD;
      end
      ST_HEAD_RD: begin
        if (count == '0) begin
          head_next  = '0;
          state_next = ST_FINISH;
        end else begin
          rd_addr    = '0;
          state_next = ST_HEAD_CHK;
        end
      end
      ST_HEAD_CHK: begin
        head_next  = rd_data.fire_time;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          out_valid_next             = 1'b1;
          out_data_next.status       = fail;
          out_data_next.removed_id   = rem_id;
          out_data_next.removed_time = rem_time;
          out_data_next.head_time    = head;
          out_data_next.queue_empty  = (count == '0);
          out_data_next.queue_length = len_ext[LEN_W-1:0];
          state_next                 = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    act      <= act_next;
    req_time <= req_time_next;
    req_id   <= req_id_next;
    idx      <= idx_next;
    mv       <= mv_next;
    fail     <= fail_next;
    rem_time <= rem_time_next;
    rem_id   <= rem_id_next;
    head     <= head_next;
    out_data <= out_data_next;
  end

`include "sorted_alarm_queue_top_assert.svh"

  `SAQ_ASSERT_IMP(a_count_bound, 1'b1, count <= FULL_COUNT, "alarm count above depth")
  `SAQ_ASSERT_NEXT(a_count_hold, (state != ST_PLACE && state != ST_MOVE_RD), count == $past(count), "alarm count changed outside place or shift end")
  `SAQ_ASSERT_IMP(a_empty_head, (out_valid && out_data.queue_empty), (out_data.head_time == 32'd0 && out_data.queue_length == 5'd0), "empty queue reports head or length")
  `SAQ_ASSERT_IMP(a_remove_fields, (out_valid && out_data.status), (out_data.removed_id == 16'd0 && out_data.removed_time == 32'd0), "failed operation reports a removed alarm")

endmodule

@@ verif/tb_sorted_alarm_queue_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_alarm_queue_top
// Self-checking bench for the sorted alarm queue. A scoreboard keeps its own
// sorted copy of the alarms, predicts the result word of every accepted
// operation and compares each returned word field by field, in order. A short
// directed run covers empty, tie, extreme and missing-id cases; a random run
// alternates fill, drain and mixed phases so the queue goes full and empty
// many times. Both handshakes stall at random.
// ---------------------------------------------------------------------------
module tb_sorted_alarm_queue_top;
  import saq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_OPS   = 900;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 80;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_MIXED
  } mix_mode_t;

  // Sorted copy of the alarm store plus the words still owed by the block.
  class alarm_scoreboard;
    entry_t      slots [QUEUE_DEPTH];
    int unsigned count;
    out_word_t   owed_q [$];
    int unsigned errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void remove_slot(int unsigned pos);
      for (int unsigned i = pos; i + 1 < count; i++) slots[i] = slots[i + 1];
      count--;
    endfunction

    function void note_input(in_word_t w);
      out_word_t   res;
      int unsigned pos;
      res = '0;
      case (action_t'(w.action))
        ACT_INSERT: begin
          if (count >= QUEUE_DEPTH) begin
            res.status = 1'b1;
          end else begin
            pos = 0;
            while (pos < count && slots[pos].fire_time < w.fire_time) pos++;
            for (int unsigned i = count; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos].fire_time = w.fire_time;
            slots[pos].alarm_tag = w.alarm_tag;
            count++;
          end
        end
        ACT_DEQUEUE: begin
          if (count == 0) begin
            res.status = 1'b1;
          end else begin
            res.removed_id   = slots[0].alarm_tag;
            res.removed_time = slots[0].fire_time;
            remove_slot(0);
          end
        end
        ACT_DELETE: begin
          pos = 0;
          while (pos < count && slots[pos].alarm_tag != w.alarm_tag) pos++;
          if (pos >= count) begin
            res.status = 1'b1;
          end else begin
            res.removed_id   = slots[pos].alarm_tag;
            res.removed_time = slots[pos].fire_time;
            remove_slot(pos);
          end
        end
        default: ;
      endcase
      res.head_time    = (count > 0) ? slots[0].fire_time : 32'd0;
      res.queue_empty  = (count == 0);
      res.queue_length = count[LEN_W-1:0];
      owed_q.push_back(res);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected word: st=%0d rid=%h rt=%h ht=%h emp=%0d len=%0d",
                   $time, got.status, got.removed_id, got.removed_time,
                   got.head_time, got.queue_empty, got.queue_length);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.removed_id !== want.removed_id ||
          got.removed_time !== want.removed_time || got.head_time !== want.head_time ||
          got.queue_empty !== want.queue_empty ||
          got.queue_length !== want.queue_length) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch exp: st=%0d rid=%h rt=%h ht=%h emp=%0d len=%0d",
                   $time, want.status, want.removed_id, want.removed_time,
                   want.head_time, want.queue_empty, want.queue_length);
          $display("[%0t]          got: st=%0d rid=%h rt=%h ht=%h emp=%0d len=%0d",
                   $time, got.status, got.removed_id, got.removed_time,
                   got.head_time, got.queue_empty, got.queue_length);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic        no_idle     = 1'b0;
  int unsigned idle_cycles = 0;
  alarm_scoreboard sb;

  sorted_alarm_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check returned words and stall the result side at random.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= no_idle || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Present one word, hold it until taken, then record it.
  task automatic send_word(input in_word_t w);
    // drop valid and idle at random before presenting the word
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  task automatic send_op(input action_t act, input logic [31:0] t, input logic [15:0] id);
    in_word_t w;
    w.action    = act;
    w.fire_time = t;
    w.alarm_tag = id;
    send_word(w);
  endtask

  initial begin
    in_word_t    w;
    mix_mode_t   mode;
    int          phase_left;
    int          roll;
    int          ins_pct;
    int          deq_pct;
    int          del_pct;

    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, extremes, ties, middle/tail/missing deletes.
    send_op(ACT_QUERY,   32'h0000_0000, 16'h0000);
    send_op(ACT_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(ACT_DELETE,  32'h0000_0000, 16'h0000);
    send_op(ACT_INSERT,  32'hFFFF_FFFF, 16'hFFFF);
    send_op(ACT_INSERT,  32'h0000_0000, 16'h0000);
    send_op(ACT_INSERT,  32'd100,       16'd1);
    send_op(ACT_INSERT,  32'd100,       16'd2);
    send_op(ACT_INSERT,  32'hFFFF_FFFF, 16'd3);
    send_op(ACT_QUERY,   32'hFFFF_FFFF, 16'hFFFF);
    send_op(ACT_DELETE,  32'h0,         16'd1);
    send_op(ACT_DELETE,  32'h0,         16'h1234);
    send_op(ACT_DELETE,  32'h0,         16'hFFFF);
    send_op(ACT_DEQUEUE, 32'h0,         16'h0);
    send_op(ACT_INSERT,  32'h0000_0000, 16'd7);
    send_op(ACT_INSERT,  32'd50,        16'd2);
    send_op(ACT_DELETE,  32'h0,         16'd2);
    send_op(ACT_DEQUEUE, 32'h0,         16'h0);
    send_op(ACT_DEQUEUE, 32'h0,         16'h0);
    send_op(ACT_DEQUEUE, 32'h0,         16'h0);
    send_op(ACT_DEQUEUE, 32'h0,         16'h0);
    send_op(ACT_DEQUEUE, 32'h0,         16'h0);
    send_op(ACT_QUERY,   32'h5A5A_A5A5, 16'hA5A5);

    // Random: fill, drain and mixed phases of random length.
    mode       = MIX_FILL;
    phase_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 300) begin
        // hold the sender until every owed word has come back
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      no_idle <= (n >= 450 && n < 600);

      if (phase_left == 0) begin
        case ($urandom_range(2))
          0:       mode = MIX_FILL;
          1:       mode = MIX_DRAIN;
          default: mode = MIX_MIXED;
        endcase
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      case (mode)
        MIX_FILL:  begin ins_pct = 70; deq_pct = 10; del_pct = 10; end
        MIX_DRAIN: begin ins_pct = 15; deq_pct = 40; del_pct = 35; end
        default:   begin ins_pct = 40; deq_pct = 25; del_pct = 25; end
      endcase

      w.fire_time = $urandom();
      w.alarm_tag = 16'($urandom_range(0, 65535));
      roll = $urandom_range(99);
      if (roll < ins_pct) begin
        w.action = ACT_INSERT;
        roll = $urandom_range(99);
        if (roll < 30) w.fire_time = $urandom_range(0, 15);
        else if (roll < 35) w.fire_time = 32'h0000_0000;
        else if (roll < 40) w.fire_time = 32'hFFFF_FFFF;
        if ($urandom_range(1) == 0) w.alarm_tag = 16'($urandom_range(0, 7));
      end else if (roll < ins_pct + deq_pct) begin
        w.action = ACT_DEQUEUE;
      end else if (roll < ins_pct + deq_pct + del_pct) begin
        w.action = ACT_DELETE;
        if (sb.count > 0 && $urandom_range(99) < 70)
          w.alarm_tag = sb.slots[$urandom_range(sb.count - 1)].alarm_tag;
        else if ($urandom_range(1) == 0)
          w.alarm_tag = 16'($urandom_range(0, 7));
      end else begin
        w.action = ACT_QUERY;
      end
      send_word(w);
    end

    in_valid <= 1'b0;
    no_idle  <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
